// ===== rtl/core/pstc_pkg.sv =====
`timescale 1ns / 1ps

package pstc_pkg;

  localparam int MaxLen    = 4096;
  localparam int Alphabet  = 26;
  localparam int Nodes     = MaxLen + 2;
  localparam int EdgeDepth = Nodes * Alphabet;
  localparam int TextDepth = MaxLen + 1;

  localparam int LetterW = 5;
  localparam int NodeW   = $clog2(Nodes + 1);
  localparam int PosW    = $clog2(MaxLen + 1);
  localparam int TextAw  = $clog2(TextDepth);
  localparam int NodeAw  = $clog2(Nodes);
  localparam int EdgeAw  = $clog2(EdgeDepth);
  localparam int CountW  = 13;
  localparam int TotalW  = 24;

  localparam logic [NodeW-1:0]  OddRoot  = NodeW'(0);
  localparam logic [NodeW-1:0]  EvenRoot = NodeW'(1);
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // One row of the node store. Parent and letter let the edge lookup tell a
  // genuine edge from a stale entry left by an earlier string.
  typedef struct packed {
    logic [NodeW-1:0]   len;
    logic [NodeW-1:0]   link;
    logic [NodeW-1:0]   depth;
    logic [NodeW-1:0]   parent;
    logic [LetterW-1:0] letter;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WA,
    S_WB,
    S_WC,
    S_EA,
    S_EB,
    S_EC,
    S_LA,
    S_LB,
    S_LC,
    S_ACC,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/pstc_ram.sv =====
`timescale 1ns / 1ps

module pstc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/palindromic_suffix_counter_unit.sv =====
`timescale 1ns / 1ps

// Palindromic suffix counter: grows a palindromic tree over a letter stream.
// Input channel: letter_i and new_string_i, taken when in_valid_i is high and
// in_stall_o is low. in_stall_o is high from the accepted transaction until its
// result has been moved into the output register.
// Output channel: pal_count_o, letter_total_o and overflow_o, offered with
// out_valid_o and held while out_stall_i is high. The output register lets
// the next transaction be taken while a result still waits.
// Steps: a letter outside the alphabet or a full text store goes straight to
// the result. Otherwise the first suffix-link walk runs, then the edge
// lookup; a step whose palindrome does not fit skips its text read, and
// reaching the odd root ends the walk. A new single-letter node is created
// directly, and a longer new node first runs a second walk to find its
// suffix link. Each step is a node store read followed by a text store
// read; the walks are amortised constant.
// Reset, or new_string_i high, clears the tree, text and totals at once:
// stale edge entries are recognised by the parent and letter kept with each
// node, so no clearing pass runs.

module palindromic_suffix_counter_unit
  import pstc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [LetterW-1:0] letter_i,
  input  logic               new_string_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CountW-1:0]  pal_count_o,
  output logic [TotalW-1:0]  letter_total_o,
  output logic               overflow_o
);

  state_e state_q, state_d;

  logic [PosW-1:0]    pos_q;
  logic [NodeW-1:0]   node_cnt_q;
  logic [NodeW-1:0]   suf_q;
  logic [TotalW-1:0]  sums_q [Alphabet];
  logic [LetterW-1:0] letter_q;
  logic [NodeW-1:0]   v_q, len_q, link_q;
  logic [NodeW-1:0]   cur_q, cur_len_q, cur_link_q;
  logic               cur_odd_q;
  logic               walk2_q;
  logic [NodeW-1:0]   t_q, lk_q, nd_len_q;
  logic [NodeW-1:0]   cnt_q;
  logic [CountW-1:0]  res_cnt_q;
  logic [TotalW-1:0]  res_tot_q;
  logic               res_ov_q;
  logic               out_valid_q;
  logic [CountW-1:0]  out_cnt_q;
  logic [TotalW-1:0]  out_tot_q;
  logic               out_ov_q;

  logic               in_acc;
  logic               out_free;
  logic [PosW-1:0]    pos_eff;
  logic               letter_ok;
  logic               text_full;

  logic               text_we;
  logic [TextAw-1:0]  text_waddr, text_raddr;
  logic [LetterW-1:0] text_rd;
  logic               node_we;
  logic [NodeAw-1:0]  node_waddr, node_raddr;
  node_t              node_wd, node_rd;
  logic               edge_we;
  logic [EdgeAw-1:0]  edge_waddr, edge_raddr;
  logic [NodeW-1:0]   edge_rd;

  logic [NodeW-1:0]   wb_len, wb_link;
  logic               wb_fit;
  logic [NodeW:0]     wb_need;
  logic               edge_ok;
  logic [NodeW-1:0]   lk_depth;
  logic [TotalW:0]    sum_wide;
  logic [TotalW-1:0]  sum_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pos_eff    = new_string_i ? '0 : pos_q;
  assign letter_ok  = (letter_i < LetterW'(Alphabet));
  assign text_full  = (pos_eff >= PosW'(MaxLen));

  // The even root is never stored; its length and link are constants.
  assign wb_len  = (v_q == EvenRoot) ? NodeW'(0) : node_rd.len;
  assign wb_link = (v_q == EvenRoot) ? OddRoot : node_rd.link;
  assign wb_need = {1'b0, wb_len} + (NodeW + 1)'(2);
  assign wb_fit  = ({1'b0, NodeW'(pos_q)} >= wb_need);

  assign edge_ok = (t_q >= NodeW'(2)) && (t_q < node_cnt_q) &&
                   (node_rd.parent == cur_q) && (node_rd.letter == letter_q);
  assign lk_depth = (lk_q == EvenRoot) ? NodeW'(0) : node_rd.depth;

  assign sum_wide = {1'b0, sums_q[letter_q]} + (TotalW + 1)'(cnt_q);
  assign sum_sat  = sum_wide[TotalW] ? TotalMax : sum_wide[TotalW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (letter_ok && !text_full) ? S_WA : S_DONE;
        end
      end
      S_WA: begin
        if (v_q == OddRoot) begin
          state_d = walk2_q ? S_LA : S_EA;
        end else begin
          state_d = S_WB;
        end
      end
      S_WB:   state_d = wb_fit ? S_WC : S_WA;
      S_WC: begin
        if (text_rd == letter_q) begin
          state_d = walk2_q ? S_LA : S_EA;
        end else begin
          state_d = S_WA;
        end
      end
      S_EA:   state_d = S_EB;
      S_EB:   state_d = S_EC;
      S_EC: begin
        if (edge_ok || (node_cnt_q >= NodeW'(Nodes))) begin
          state_d = S_ACC;
        end else begin
          state_d = cur_odd_q ? S_LC : S_WA;
        end
      end
      S_LA:   state_d = S_LB;
      S_LB:   state_d = S_LC;
      S_LC:   state_d = S_ACC;
      S_ACC:  state_d = S_DONE;
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    text_we    = 1'b0;
    text_waddr = TextAw'(pos_eff + PosW'(1));
    text_raddr = TextAw'(pos_q - PosW'(wb_len) - PosW'(1));
    node_we    = 1'b0;
    node_waddr = NodeAw'(node_cnt_q);
    node_raddr = NodeAw'(v_q);
    node_wd    = '{len: nd_len_q, link: lk_q, depth: lk_depth + NodeW'(1),
                   parent: cur_q, letter: letter_q};
    edge_we    = 1'b0;
    edge_waddr = EdgeAw'(cur_q) * EdgeAw'(Alphabet) + EdgeAw'(letter_q);
    edge_raddr = EdgeAw'(cur_q) * EdgeAw'(Alphabet) + EdgeAw'(letter_q);
    unique case (state_q)
      S_IDLE: text_we = in_acc && letter_ok && !text_full;
      S_EB:   node_raddr = NodeAw'(edge_rd);
      S_LA:   edge_raddr = EdgeAw'(v_q) * EdgeAw'(Alphabet) + EdgeAw'(letter_q);
      S_LB:   node_raddr = NodeAw'(edge_rd);
      S_LC: begin
        node_we = 1'b1;
        edge_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      node_cnt_q <= NodeW'(2);
      suf_q      <= EvenRoot;
      walk2_q    <= 1'b0;
      for (int i = 0; i < Alphabet; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (new_string_i) begin
              pos_q      <= '0;
              node_cnt_q <= NodeW'(2);
              suf_q      <= EvenRoot;
              for (int i = 0; i < Alphabet; i++) begin
                sums_q[i] <= '0;
              end
            end
            if (letter_ok && !text_full) begin
              pos_q <= pos_eff + PosW'(1);
            end
            walk2_q <= 1'b0;
          end
        end
        S_EC: begin
          if (edge_ok) begin
            suf_q <= t_q;
          end else if (node_cnt_q >= NodeW'(Nodes)) begin
            suf_q <= OddRoot;
          end else if (!cur_odd_q) begin
            walk2_q <= 1'b1;
          end
        end
        S_LC: begin
          suf_q      <= node_cnt_q;
          node_cnt_q <= node_cnt_q + NodeW'(1);
        end
        S_ACC: sums_q[letter_q] <= sum_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          letter_q  <= letter_i;
          v_q       <= new_string_i ? EvenRoot : suf_q;
          res_cnt_q <= '0;
          res_ov_q  <= letter_ok;
          res_tot_q <= (letter_ok && !new_string_i) ? sums_q[letter_i] : '0;
        end
      end
      S_WA: begin
        if (v_q == OddRoot && !walk2_q) begin
          cur_q      <= v_q;
          cur_odd_q  <= 1'b1;
          cur_len_q  <= '0;
          cur_link_q <= EvenRoot;
        end
      end
      S_WB: begin
        len_q  <= wb_len;
        link_q <= wb_link;
        if (!wb_fit) begin
          v_q <= wb_link;
        end
      end
      S_WC: begin
        if (text_rd == letter_q) begin
          if (!walk2_q) begin
            cur_q      <= v_q;
            cur_odd_q  <= 1'b0;
            cur_len_q  <= len_q;
            cur_link_q <= link_q;
          end
        end else begin
          v_q <= link_q;
        end
      end
      S_EB: t_q <= edge_rd;
      S_EC: begin
        if (edge_ok) begin
          cnt_q <= node_rd.depth;
        end else if (node_cnt_q >= NodeW'(Nodes)) begin
          cnt_q <= '0;
        end else begin
          nd_len_q <= cur_odd_q ? NodeW'(1) : cur_len_q + NodeW'(2);
          lk_q     <= EvenRoot;
          v_q      <= cur_link_q;
        end
      end
      S_LB: lk_q <= edge_rd;
      S_LC: cnt_q <= lk_depth + NodeW'(1);
      S_ACC: begin
        res_cnt_q <= CountW'(cnt_q);
        res_tot_q <= sum_sat;
        res_ov_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_cnt_q <= res_cnt_q;
      out_tot_q <= res_tot_q;
      out_ov_q  <= res_ov_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pal_count_o    = out_cnt_q;
  assign letter_total_o = out_tot_q;
  assign overflow_o     = out_ov_q;

  pstc_ram #(.DEPTH(TextDepth), .WIDTH(LetterW)) u_text (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (text_waddr),
    .wdata_i (letter_i),
    .raddr_i (text_raddr),
    .rdata_o (text_rd)
  );

  pstc_ram #(.DEPTH(Nodes), .WIDTH($bits(node_t))) u_node (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wd),
    .raddr_i (node_raddr),
    .rdata_o (node_rd)
  );

  pstc_ram #(.DEPTH(EdgeDepth), .WIDTH(NodeW)) u_edge (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (node_cnt_q),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  a_node_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_cnt_q <= NodeW'(Nodes))
    else $error("node count beyond pool size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MaxLen))
    else $error("text position beyond store");

  a_suffix_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    suf_q < node_cnt_q)
    else $error("suffix node not yet created");

  a_create_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LC |=> node_cnt_q == $past(node_cnt_q) + NodeW'(1))
    else $error("node creation did not advance the pool");

endmodule
